// ===== rtl/nearest_color_classifier_macros.svh =====
// Assertion macros for the nearest colour classifier checker.
// Needs signals named clock and reset in the module that uses them.
`ifndef NEAREST_COLOR_CLASSIFIER_MACROS_SVH
`define NEAREST_COLOR_CLASSIFIER_MACROS_SVH

// Same-cycle implication, off while in reset
`define NCC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while in reset
`define NCC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication that also holds through reset
`define NCC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/ncc_pkg.sv =====
// Shared types and constants of the nearest colour classifier.
// No dependencies.
`timescale 1ns / 1ps
package ncc_pkg;

   // result codes
   typedef enum logic [2:0] {
      CLS_NOT_CAL  = 3'd0,
      CLS_NO_SIG   = 3'd1,
      CLS_WHITE    = 3'd2,
      CLS_BLACK    = 3'd3,
      CLS_RED      = 3'd4,
      CLS_GREEN    = 3'd5,
      CLS_BLUE     = 3'd6
   } color_class_type;

   // register indexes
   typedef enum logic [2:0] {
      CSR_CAL       = 3'd0,
      CSR_BLACK_THR = 3'd1,
      CSR_WHITE_REF = 3'd2,
      CSR_P_WHITE   = 3'd3,
      CSR_P_RED     = 3'd4,
      CSR_P_GREEN   = 3'd5,
      CSR_P_BLUE    = 3'd6
   } csr_index_type;

   localparam int NUM_PROFILES = 4;
   localparam int SLOT_BITS    = 16;
   localparam int CSR_WIDTH    = 64;

   // profile position to class code
   function automatic color_class_type prof_class(input logic [1:0] idx);
      color_class_type c;
      case (idx)
         2'd0:    c = CLS_WHITE;
         2'd1:    c = CLS_RED;
         2'd2:    c = CLS_GREEN;
         default: c = CLS_BLUE;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/ncc_div.sv =====
// One lane of the pipelined restoring divider: floor(num * 2^SHIFT / den),
// saturated to all ones, zero for a zero divisor. Uses nothing else.
`timescale 1ns / 1ps
module ncc_div #(
   parameter int FREQ_BITS    = 17,
   parameter int FEATURE_BITS = 16,
   parameter int SHIFT        = 16
) (
   input  logic                    clock,
   input  logic                    adv,
   input  logic [FREQ_BITS-1:0]    num,
   input  logic [FREQ_BITS+1:0]    den,
   output logic [FEATURE_BITS-1:0] quot
);
   localparam int W  = FREQ_BITS + 2 + FEATURE_BITS;
   localparam int F  = FEATURE_BITS;

   logic [W-1:0] rem_ff [0:F];
   logic [W-1:0] den_ff [0:F];
   logic [F-1:0] q_ff   [0:F];
   logic         sat_ff [0:F];
   logic         zero_ff[0:F];

   logic [W-1:0] num_w;
   logic [W-1:0] den_w;

   assign num_w = {{(W-FREQ_BITS){1'b0}}, num} << SHIFT;
   assign den_w = {{(W-FREQ_BITS-2){1'b0}}, den};

   // entry: saturation and zero-divisor tests
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= num_w;
         den_ff[0]  <= den_w;
         q_ff[0]    <= '0;
         sat_ff[0]  <= num_w >= (den_w << F);
         zero_ff[0] <= den == '0;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 1; k <= F; k++) begin : g_stage
      localparam int I = F - k;
      logic [W-1:0] trial;
      logic         hit;
      assign trial = den_ff[k-1] << I;
      assign hit   = rem_ff[k-1] >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= hit ? rem_ff[k-1] - trial : rem_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            q_ff[k]    <= q_ff[k-1] | ({{(F-1){1'b0}}, hit} << I);
            sat_ff[k]  <= sat_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   assign quot = zero_ff[F] ? '0 : (sat_ff[F] ? '1 : q_ff[F]);

endmodule

// ===== rtl/ncc_dist.sv =====
// Weighted distance to the four profiles and nearest pick, three stages.
// Depends on ncc_pkg.
`timescale 1ns / 1ps
module ncc_dist #(
   parameter int FEATURE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [FEATURE_BITS-1:0]       feat [0:3],
   input  logic [ncc_pkg::CSR_WIDTH-1:0] prof [0:3],
   output ncc_pkg::color_class_type      cls
);
   import ncc_pkg::*;

   localparam int F  = FEATURE_BITS;
   localparam int SQ = 2 * F;
   localparam int DW = 2 * F + 5;

   logic [SQ-1:0] sq_ff  [0:3][0:3];
   logic [DW-1:0] dist_ff[0:3];
   color_class_type cls_ff;

   logic [F-1:0]  diff [0:3][0:3];
   logic [DW-1:0] dist_in[0:3];
   logic [1:0]    win_a, win_b, win;
   logic [DW-1:0] best_a, best_b;

   // absolute feature differences
   always_comb begin
      for (int p = 0; p < 4; p++) begin
         for (int k = 0; k < 4; k++) begin
            diff[p][k] = (feat[k] >= prof[p][SLOT_BITS*k +: F])
                       ? feat[k] - prof[p][SLOT_BITS*k +: F]
                       : prof[p][SLOT_BITS*k +: F] - feat[k];
         end
      end
   end

   // stage A: squares
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < 4; p++) begin
            for (int k = 0; k < 4; k++) begin
               sq_ff[p][k] <= diff[p][k] * diff[p][k];
            end
         end
      end
   end

   // weights 6,6,6,3
   always_comb begin
      for (int p = 0; p < 4; p++) begin
         dist_in[p] = (({5'd0, sq_ff[p][0]} + {5'd0, sq_ff[p][1]} + {5'd0, sq_ff[p][2]})
                       * DW'(6)) + ({5'd0, sq_ff[p][3]} * DW'(3));
      end
   end

   // stage B: distances
   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff <= dist_in;
      end
   end

   // nearest, earlier profile wins a tie
   always_comb begin
      win_a  = (dist_ff[1] < dist_ff[0]) ? 2'd1 : 2'd0;
      best_a = (dist_ff[1] < dist_ff[0]) ? dist_ff[1] : dist_ff[0];
      win_b  = (dist_ff[3] < dist_ff[2]) ? 2'd3 : 2'd2;
      best_b = (dist_ff[3] < dist_ff[2]) ? dist_ff[3] : dist_ff[2];
      win    = (best_b < best_a) ? win_b : win_a;
   end

   // stage C: class
   always_ff @(posedge clock) begin
      if (adv) begin
         cls_ff <= prof_class(win);
      end
   end

   assign cls = cls_ff;

endmodule

// ===== rtl/nearest_color_classifier.sv =====
// Nearest colour classifier: each accepted word passes the input registers,
// the one-bit-per-stage divider lanes, the distance stages and the result
// register; one word per cycle is sustained while the result word is not
// stalled. The whole pipeline holds while the result word is stalled.
// Synchronous reset clears valid bits and sets the configuration registers to their reset values.
`timescale 1ns / 1ps
module nearest_color_classifier #(
   parameter int FREQ_BITS    = 17,
   parameter int FEATURE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [FREQ_BITS-1:0]          req_red_freq,
   input  logic [FREQ_BITS-1:0]          req_green_freq,
   input  logic [FREQ_BITS-1:0]          req_blue_freq,
   input  logic [FREQ_BITS-1:0]          req_clear_freq,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_color_class,
   input  logic                          csr_write,
   input  logic [2:0]                    csr_index,
   input  logic [ncc_pkg::CSR_WIDTH-1:0] csr_wdata
);
   import ncc_pkg::*;

   localparam int DLY = FEATURE_BITS + 5;

   // configuration
   logic                 cal_ff;
   logic [FREQ_BITS-1:0] thr_ff;
   logic [FREQ_BITS-1:0] wref_ff;
   logic [CSR_WIDTH-1:0] prof_ff [0:3];

   // input stage
   logic [FREQ_BITS-1:0] r_ff, g_ff, b_ff, c_ff;
   logic [FREQ_BITS+1:0] sum_ff;

   // valid and early-decision line
   logic            v_ff    [0:DLY-1];
   logic            early_ff[0:DLY-1];
   color_class_type code_ff [0:DLY-1];
   logic            early_in;
   color_class_type code_in;

   // output word
   logic            out_v_ff;
   color_class_type out_cls_ff;

   logic                    adv;
   logic [FEATURE_BITS-1:0] feat [0:3];
   color_class_type         dist_cls;

   assign adv       = !out_v_ff || !rsp_stall;
   assign req_stall = !adv;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff  <= 1'b0;
         thr_ff  <= '0;
         wref_ff <= FREQ_BITS'(1);
         for (int p = 0; p < NUM_PROFILES; p++) prof_ff[p] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CAL:       cal_ff     <= csr_wdata[0];
            CSR_BLACK_THR: thr_ff     <= csr_wdata[FREQ_BITS-1:0];
            CSR_WHITE_REF: wref_ff    <= csr_wdata[FREQ_BITS-1:0];
            CSR_P_WHITE:   prof_ff[0] <= csr_wdata;
            CSR_P_RED:     prof_ff[1] <= csr_wdata;
            CSR_P_GREEN:   prof_ff[2] <= csr_wdata;
            CSR_P_BLUE:    prof_ff[3] <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // special cases decided on entry
   always_comb begin
      early_in = 1'b1;
      code_in  = CLS_NOT_CAL;
      if (!cal_ff) begin
         code_in = CLS_NOT_CAL;
      end else if (req_red_freq == '0 && req_green_freq == '0 &&
                   req_blue_freq == '0 && req_clear_freq == '0) begin
         code_in = CLS_NO_SIG;
      end else if (req_clear_freq < thr_ff) begin
         code_in = CLS_BLACK;
      end else begin
         early_in = 1'b0;
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff        <= req_red_freq;
         g_ff        <= req_green_freq;
         b_ff        <= req_blue_freq;
         c_ff        <= req_clear_freq;
         sum_ff      <= {2'b00, req_red_freq} + {2'b00, req_green_freq}
                      + {2'b00, req_blue_freq};
         early_ff[0] <= early_in;
         code_ff[0]  <= code_in;
         for (int j = 1; j < DLY; j++) begin
            early_ff[j] <= early_ff[j-1];
            code_ff[j]  <= code_ff[j-1];
         end
      end
   end

   // valid bits travel with the words
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DLY; j++) v_ff[j] <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int j = 1; j < DLY; j++) v_ff[j] <= v_ff[j-1];
         out_v_ff <= v_ff[DLY-1];
      end
   end

   // divider lanes: three ratios and brightness
   ncc_div #(.FREQ_BITS(FREQ_BITS), .FEATURE_BITS(FEATURE_BITS), .SHIFT(FEATURE_BITS))
      u_div_r (.clock(clock), .adv(adv), .num(r_ff), .den(sum_ff), .quot(feat[0]));
   ncc_div #(.FREQ_BITS(FREQ_BITS), .FEATURE_BITS(FEATURE_BITS), .SHIFT(FEATURE_BITS))
      u_div_g (.clock(clock), .adv(adv), .num(g_ff), .den(sum_ff), .quot(feat[1]));
   ncc_div #(.FREQ_BITS(FREQ_BITS), .FEATURE_BITS(FEATURE_BITS), .SHIFT(FEATURE_BITS))
      u_div_b (.clock(clock), .adv(adv), .num(b_ff), .den(sum_ff), .quot(feat[2]));
   ncc_div #(.FREQ_BITS(FREQ_BITS), .FEATURE_BITS(FEATURE_BITS),
             .SHIFT(FEATURE_BITS-2))
      u_div_c (.clock(clock), .adv(adv), .num(c_ff), .den({2'b00, wref_ff}),
               .quot(feat[3]));

   ncc_dist #(.FEATURE_BITS(FEATURE_BITS)) u_dist (
      .clock (clock),
      .adv   (adv),
      .feat  (feat),
      .prof  (prof_ff),
      .cls   (dist_cls)
   );

   // result word
   always_ff @(posedge clock) begin
      if (adv) begin
         out_cls_ff <= early_ff[DLY-1] ? code_ff[DLY-1] : dist_cls;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_color_class = out_cls_ff;

endmodule

// ===== rtl/ncc_checker.sv =====
// Port-level checks for the nearest colour classifier, bound to the top.
// Depends on nearest_color_classifier_macros.svh.
`timescale 1ns / 1ps
`include "nearest_color_classifier_macros.svh"
module ncc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_color_class
);
   // input holds only while a result word is stuck
   `NCC_ASSERT_NOW(a_stall_src, 1'b1, req_stall == (rsp_valid && rsp_stall), "req_stall mismatch")
   // a stuck result word holds
   `NCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_color_class), "rsp word changed while stalled")
   // only defined codes come out
   `NCC_ASSERT_NOW(a_code, rsp_valid, rsp_color_class <= 3'd6, "undefined class code")
   // nothing comes out straight after reset
   `NCC_ASSERT_ALWAYS(a_reset, $past(reset), !rsp_valid, "result word after reset")
endmodule

bind nearest_color_classifier ncc_checker u_ncc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_color_class (rsp_color_class)
);
